// ===== rtl/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Shared types, character codes and screen defaults for the text terminal.
// ----------------------------------------------------------------------------
package att_pkg;

   localparam int SCREEN_COLUMNS_DEF     = 80;
   localparam int SCREEN_ROWS_DEF        = 24;
   localparam int MAX_SEQUENCE_BYTES_DEF = 32;

   // cursor coordinates and sequence length fit 8 bits over the whole range
   localparam int POS_W  = 8;
   localparam int CELL_W = 15;
   localparam int ARG_W  = 10;

   localparam logic [CELL_W-1:0] RESET_CELL = 15'h0720;
   localparam logic [13:0]       ARG_LIMIT  = 14'd999;
   localparam logic [6:0]        ATTR_RESET = 7'd7;

   localparam logic ACT_FEED = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_CAN   = 8'd24;
   localparam logic [7:0] CH_SUB   = 8'd26;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7e;

   localparam logic [7:0] CMD_SGR  = 8'h6d;
   localparam logic [7:0] CMD_CUP  = 8'h48;
   localparam logic [7:0] CMD_HVP  = 8'h66;
   localparam logic [7:0] CMD_CUU  = 8'h41;
   localparam logic [7:0] CMD_CUD  = 8'h42;
   localparam logic [7:0] CMD_CUF  = 8'h43;
   localparam logic [7:0] CMD_CUB  = 8'h44;
   localparam logic [7:0] CMD_ED   = 8'h4a;
   localparam logic [7:0] CMD_EL   = 8'h4b;

   typedef struct packed {
      logic        action;
      logic [7:0]  byte_in;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [4:0]        cursor_row;
      logic [6:0]        cursor_column;
      logic              pending_wrap;
      logic [6:0]        current_attribute;
      logic [CELL_W-1:0] cell_value;
      logic              screen_changed;
   } rsp_type;

   function automatic logic [2:0] colour_map(input logic [2:0] idx);
      logic [2:0] r;
      case (idx)
         3'd0: r = 3'd0;
         3'd1: r = 3'd4;
         3'd2: r = 3'd2;
         3'd3: r = 3'd6;
         3'd4: r = 3'd1;
         3'd5: r = 3'd5;
         3'd6: r = 3'd3;
         default: r = 3'd7;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/att_ifc.sv =====
// ----------------------------------------------------------------------------
// att_ifc
// Valid/ready channels for requests and responses of the text terminal.
// ----------------------------------------------------------------------------
interface att_req_if;
   logic             valid;
   logic             ready;
   att_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface att_rsp_if;
   logic             valid;
   logic             ready;
   att_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/att_mem.sv =====
// ----------------------------------------------------------------------------
// att_mem
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module att_mem #(
   parameter int DEPTH = att_pkg::SCREEN_COLUMNS_DEF * att_pkg::SCREEN_ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [att_pkg::CELL_W-1:0] wdata,
   input  logic [AW-1:0]             raddr,
   output logic [att_pkg::CELL_W-1:0] rdata
);
   import att_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/att_ctrl.sv =====
// ----------------------------------------------------------------------------
// att_ctrl
// Escape parser, cursor state and the sequencer that walks the cell store.
// ----------------------------------------------------------------------------
module att_ctrl #(
   parameter int SCREEN_COLUMNS     = att_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS        = att_pkg::SCREEN_ROWS_DEF,
   parameter int MAX_SEQUENCE_BYTES = att_pkg::MAX_SEQUENCE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  att_pkg::req_type item,
   output logic             item_ready,
   input  logic             slot_free,
   output logic             res_valid,
   output att_pkg::rsp_type res
);
   import att_pkg::*;

   localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = AW + 1;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_READ   = 7'b0000100,
      S_SCROLL = 7'b0001000,
      S_BLANK  = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      E_NORM = 4'b0001,
      E_ESC  = 4'b0010,
      E_CSI  = 4'b0100,
      E_IGN  = 4'b1000
   } esc_type;

   state_type         state_ff, state_in;
   esc_type           esc_ff, esc_in;
   logic [ARG_W-1:0]  arg_ff [4];
   logic [ARG_W-1:0]  arg_in [4];
   logic [1:0]        argi_ff, argi_in;
   logic [POS_W-1:0]  seql_ff, seql_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic              wrap_ff, wrap_in;
   logic [6:0]        attr_ff, attr_in;
   logic              dirty_ff, dirty_in;
   logic [PW-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     wa_ff, wa_in;
   logic              wv_ff, wv_in;
   logic              wpend_ff, wpend_in;
   logic [7:0]        char_ff, char_in;
   logic [CELL_W-1:0] value_ff, value_in;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [CELL_W-1:0] wdata;
   logic [AW-1:0]     raddr;
   logic [CELL_W-1:0] rdata;

   logic [PW-1:0]     line, pos;
   logic [7:0]        c;
   logic [ARG_W-1:0]  a0, n0, n1;
   logic [ARG_W:0]    sum;
   logic [8:0]        tab;
   logic [13:0]       dv;
   logic [ARG_W-1:0]  v;
   logic [6:0]        sa;
   logic [2:0]        cm;

   att_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign line = PW'(row_ff * SCREEN_COLUMNS);
   assign pos  = line + PW'(col_ff);
   assign c    = item.byte_in;
   assign a0   = arg_ff[0];
   assign n0   = (arg_ff[0] == '0) ? ARG_W'(1) : arg_ff[0];
   assign n1   = (arg_ff[1] == '0) ? ARG_W'(1) : arg_ff[1];

   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);

   always_comb begin
      res.cursor_row        = 5'(row_ff);
      res.cursor_column     = 7'(col_ff);
      res.pending_wrap      = wrap_ff;
      res.current_attribute = attr_ff;
      res.cell_value        = value_ff;
      res.screen_changed    = dirty_ff;
   end

   always_comb begin
      state_in = state_ff;
      esc_in   = esc_ff;
      arg_in   = arg_ff;
      argi_in  = argi_ff;
      seql_in  = seql_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      wrap_in  = wrap_ff;
      attr_in  = attr_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      wa_in    = wa_ff;
      wv_in    = 1'b0;
      wpend_in = wpend_ff;
      char_in  = char_ff;
      value_in = value_ff;
      we       = 1'b0;
      waddr    = '0;
      wdata    = '0;
      raddr    = '0;
      sum      = '0;
      tab      = '0;
      dv       = '0;
      v        = '0;
      sa       = attr_ff;
      cm       = '0;

      case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = AW'(cnt_ff);
            wdata  = RESET_CELL;
            cnt_in = cnt_ff + PW'(1);
            if (cnt_ff == PW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               state_in = S_DONE;
               value_in = '0;
               if (item.action == ACT_READ) begin
                  raddr = AW'(item.cell_index);
                  if (int'(item.cell_index) < CELLS) begin
                     state_in = S_READ;
                  end
               end else if (c == CH_ESC || c == CH_CAN || c == CH_SUB) begin
                  esc_in  = (c == CH_ESC) ? E_ESC : E_NORM;
                  argi_in = '0;
                  seql_in = '0;
                  for (int i = 0; i < 4; i++) arg_in[i] = '0;
               end else if (esc_ff != E_NORM) begin
                  if (esc_ff == E_ESC || (c >= FINAL_LO && c <= FINAL_HI)) begin
                     esc_in  = E_NORM;
                     argi_in = '0;
                     seql_in = '0;
                     for (int i = 0; i < 4; i++) arg_in[i] = '0;
                     if (esc_ff == E_ESC && c == CH_LBRK) begin
                        esc_in = E_CSI;
                     end
                     if (esc_ff == E_CSI) begin
                        // final byte runs the command
                        if (c == CMD_SGR) begin
                           for (int i = 0; i < 4; i++) begin
                              if (i <= int'(argi_ff)) begin
                                 v  = arg_ff[i];
                                 cm = colour_map(v[2:0] - 3'd6);
                                 if (v == '0) sa = ATTR_RESET;
                                 else if (v == ARG_W'(1)) sa = sa | 7'h08;
                                 else if (v == ARG_W'(22)) sa = sa & 7'h77;
                                 else if (v >= ARG_W'(30) && v <= ARG_W'(37))
                                    sa = {sa[6:3], cm};
                                 else if (v == ARG_W'(39)) sa = {sa[6:3], 3'd7};
                                 else if (v >= ARG_W'(40) && v <= ARG_W'(47))
                                    sa = {colour_map(v[2:0]), sa[3:0]};
                                 else if (v == ARG_W'(49)) sa = {3'd0, sa[3:0]};
                              end
                           end
                           attr_in = sa;
                        end else if ((c == CMD_CUP || c == CMD_HVP) && argi_ff <= 2'd1) begin
                           wrap_in = 1'b0;
                           row_in  = (n0 - ARG_W'(1) > ARG_W'(SCREEN_ROWS - 1)) ?
                                     POS_W'(SCREEN_ROWS - 1) : POS_W'(n0 - ARG_W'(1));
                           col_in  = (n1 - ARG_W'(1) > ARG_W'(SCREEN_COLUMNS - 1)) ?
                                     POS_W'(SCREEN_COLUMNS - 1) : POS_W'(n1 - ARG_W'(1));
                        end else if (argi_ff == '0) begin
                           case (c)
                              CMD_CUU: begin
                                 wrap_in = 1'b0;
                                 row_in  = (n0 >= ARG_W'(row_ff)) ? '0 :
                                           row_ff - POS_W'(n0);
                              end
                              CMD_CUD: begin
                                 wrap_in = 1'b0;
                                 sum     = (ARG_W+1)'(row_ff) + (ARG_W+1)'(n0);
                                 row_in  = (sum > (ARG_W+1)'(SCREEN_ROWS - 1)) ?
                                           POS_W'(SCREEN_ROWS - 1) : POS_W'(sum);
                              end
                              CMD_CUF: begin
                                 wrap_in = 1'b0;
                                 sum     = (ARG_W+1)'(col_ff) + (ARG_W+1)'(n0);
                                 col_in  = (sum > (ARG_W+1)'(SCREEN_COLUMNS - 1)) ?
                                           POS_W'(SCREEN_COLUMNS - 1) : POS_W'(sum);
                              end
                              CMD_CUB: begin
                                 wrap_in = 1'b0;
                                 col_in  = (n0 >= ARG_W'(col_ff)) ? '0 :
                                           col_ff - POS_W'(n0);
                              end
                              CMD_ED, CMD_EL: begin
                                 wrap_in = 1'b0;
                                 if (a0 <= ARG_W'(2)) begin
                                    state_in = S_BLANK;
                                    wpend_in = 1'b0;
                                    if (a0 == '0) begin
                                       cnt_in = pos;
                                       hi_in  = (c == CMD_ED) ? PW'(CELLS) :
                                                line + PW'(SCREEN_COLUMNS);
                                    end else if (a0 == ARG_W'(1)) begin
                                       cnt_in = (c == CMD_ED) ? '0 : line;
                                       hi_in  = pos + PW'(1);
                                    end else begin
                                       cnt_in = (c == CMD_ED) ? '0 : line;
                                       hi_in  = (c == CMD_ED) ? PW'(CELLS) :
                                                line + PW'(SCREEN_COLUMNS);
                                    end
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end else if (esc_ff == E_CSI) begin
                     if (int'(seql_ff) >= MAX_SEQUENCE_BYTES) begin
                        esc_in = E_IGN;
                     end else begin
                        seql_in = seql_ff + POS_W'(1);
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                           dv = 14'(arg_ff[argi_ff]) * 14'd10 + 14'(c - CH_ZERO);
                           if (dv > ARG_LIMIT) esc_in = E_IGN;
                           else arg_in[argi_ff] = ARG_W'(dv);
                        end else if (c == CH_SEMI && argi_ff != 2'd3) begin
                           argi_in = argi_ff + 2'd1;
                        end else begin
                           esc_in = E_IGN;
                        end
                     end
                  end
               end else if (c == CH_CR) begin
                  col_in  = '0;
                  wrap_in = 1'b0;
               end else if (c == CH_LF) begin
                  wrap_in = 1'b0;
                  if (int'(row_ff) < SCREEN_ROWS - 1) begin
                     row_in = row_ff + POS_W'(1);
                  end else begin
                     state_in = S_SCROLL;
                     cnt_in   = '0;
                     wpend_in = 1'b0;
                  end
               end else if (c == CH_BS) begin
                  wrap_in = 1'b0;
                  if (col_ff != '0) col_in = col_ff - POS_W'(1);
               end else if (c == CH_TAB) begin
                  wrap_in = 1'b0;
                  tab     = ({1'b0, col_ff} + 9'd8) & ~9'd7;
                  col_in  = (tab > 9'(SCREEN_COLUMNS - 1)) ?
                            POS_W'(SCREEN_COLUMNS - 1) : POS_W'(tab);
               end else if (c >= CH_SPACE && c != CH_DEL) begin
                  char_in  = c;
                  state_in = S_WRITE;
                  if (wrap_ff) begin
                     col_in  = '0;
                     wrap_in = 1'b0;
                     if (int'(row_ff) < SCREEN_ROWS - 1) begin
                        row_in = row_ff + POS_W'(1);
                     end else begin
                        state_in = S_SCROLL;
                        cnt_in   = '0;
                        wpend_in = 1'b1;
                     end
                  end
               end
            end
         end
         S_READ: begin
            value_in = rdata;
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // read runs one row ahead of the write, so no entry is overwritten early
            we    = wv_ff;
            waddr = wa_ff;
            wdata = rdata;
            if (cnt_ff < PW'(CELLS - SCREEN_COLUMNS)) begin
               raddr  = AW'(cnt_ff + PW'(SCREEN_COLUMNS));
               wa_in  = AW'(cnt_ff);
               wv_in  = 1'b1;
               cnt_in = cnt_ff + PW'(1);
            end else begin
               hi_in    = PW'(CELLS);
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            if (cnt_ff < hi_ff) begin
               we     = 1'b1;
               waddr  = AW'(cnt_ff);
               wdata  = {attr_ff, CH_SPACE};
               cnt_in = cnt_ff + PW'(1);
            end else begin
               state_in = wpend_ff ? S_WRITE : S_DONE;
               wpend_in = 1'b0;
            end
         end
         S_WRITE: begin
            we    = 1'b1;
            waddr = AW'(pos);
            wdata = {attr_ff, char_ff};
            if (int'(col_ff) == SCREEN_COLUMNS - 1) wrap_in = 1'b1;
            else col_in = col_ff + POS_W'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      dirty_in = dirty_ff | we;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         esc_ff   <= E_NORM;
         for (int i = 0; i < 4; i++) arg_ff[i] <= '0;
         argi_ff  <= '0;
         seql_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         wrap_ff  <= 1'b0;
         attr_ff  <= ATTR_RESET;
         dirty_ff <= 1'b1;
         cnt_ff   <= '0;
         wv_ff    <= 1'b0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         esc_ff   <= esc_in;
         arg_ff   <= arg_in;
         argi_ff  <= argi_in;
         seql_ff  <= seql_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         wrap_ff  <= wrap_in;
         attr_ff  <= attr_in;
         dirty_ff <= dirty_in;
         cnt_ff   <= cnt_in;
         wv_ff    <= wv_in;
         wpend_ff <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      wa_ff    <= wa_in;
      char_ff  <= char_in;
      value_ff <= value_in;
   end

endmodule

// ===== rtl/ansi_text_terminal_unit.sv =====
// ----------------------------------------------------------------------------
// ansi_text_terminal_unit
// Byte-fed text terminal with a cell store, cursor and escape sequence parser.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  req_ch   | in  | action, byte_in, cell_index
//  rsp_ch   | out | cursor_row/column, pending_wrap, attribute, cell, dirty
//
//  One request at a time; an erase or a scroll walks the cell store
//  cell by cell before the response. After reset a clearing pass fills
//  the store before the first request. A response register lets the
//  next request enter while the previous response waits.
// ----------------------------------------------------------------------------
module ansi_text_terminal_unit #(
   parameter int SCREEN_COLUMNS     = att_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS        = att_pkg::SCREEN_ROWS_DEF,
   parameter int MAX_SEQUENCE_BYTES = att_pkg::MAX_SEQUENCE_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   att_req_if.sink   req_ch,
   att_rsp_if.source rsp_ch
);
   import att_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    slot_free;
   logic    res_valid;
   rsp_type res;

   att_ctrl #(
      .SCREEN_COLUMNS     (SCREEN_COLUMNS),
      .SCREEN_ROWS        (SCREEN_ROWS),
      .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_ch.valid),
      .item       (req_ch.payload),
      .item_ready (req_ch.ready),
      .slot_free  (slot_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (res_valid && slot_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule
